### hdl/int64_to_radix_text_defines.svh
// Assertion macros used by the checker of the radix text converter.
`ifndef INT64_TO_RADIX_TEXT_DEFINES_SVH
`define INT64_TO_RADIX_TEXT_DEFINES_SVH

// Assert a property on a given clock, disabled while the given reset is low.
`define I2RT_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert a property on the block clock and reset.
`define I2RT_ASSERT(lbl, prop, msg) \
  `I2RT_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

### hdl/i2rt_pkg.sv
// Package with types, constants and helpers of the radix text converter.
package i2rt_pkg;

  localparam int unsigned MaxDigits = 64;
  localparam int unsigned AddrW     = $clog2(MaxDigits);
  localparam int unsigned CountW    = AddrW + 1;

  localparam logic [4:0] BaseMin   = 5'd2;
  localparam logic [4:0] BaseMax   = 5'd16;
  localparam logic [4:0] BaseReset = 5'd10;
  localparam logic [4:0] BaseEight = 5'd8;

  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrLowA  = 8'h61;
  localparam logic [7:0] ChrX     = 8'h78;
  localparam logic [7:0] ChrUpB   = 8'h42;
  localparam logic [7:0] ChrMinus = 8'h2d;
  localparam logic [7:0] ChrNone  = 8'h00;

  // Configuration register indexes.
  localparam logic [1:0] RegBase   = 2'd0;
  localparam logic [1:0] RegPrefix = 2'd1;
  localparam logic [1:0] RegSigned = 2'd2;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StDiv  = 5'b00010,
    StRead = 5'b00100,
    StChar = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic rd;
    logic ch;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic beat_done;
    logic out_last;
  } sts_t;

  // ASCII character of one digit, lowercase letters above nine.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ChrZero + {4'd0, d};
    end else begin
      c = ChrLowA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

### hdl/i2rt_ctrl.sv
// Controller state machine of the radix text converter.
module i2rt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  i2rt_pkg::sts_t sts_i,
  output i2rt_pkg::cmd_t cmd_o
);
  import i2rt_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        state_d  = StChar;
      end
      StChar: begin
        cmd_o.ch = 1'b1;
        state_d  = sts_i.beat_done ? StOut : StRead;
      end
      StOut: begin
        if (!out_stall_i) begin
          state_d = sts_i.out_last ? StIdle : StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

endmodule

### hdl/i2rt_dpath.sv
// Datapath of the radix text converter: registers, divider, digit store, beat packing.
module i2rt_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [4:0]     cfg_data_i,
  input  logic [63:0]    value_bits_i,
  input  i2rt_pkg::cmd_t cmd_i,
  output i2rt_pkg::sts_t sts_o,
  output logic [7:0]     char_first_o,
  output logic [7:0]     char_second_o,
  output logic           second_valid_o,
  output logic           last_o
);
  import i2rt_pkg::*;

  // Configuration registers.
  logic [4:0] base_q;
  logic       pfx_en_q;
  logic       sgn_q;

  // Conversion state.
  logic [63:0]       work_q;
  logic [3:0]        rem_q;
  logic [2:0]        step_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] dig_rem_q;
  logic [15:0]       pre_q;
  logic [1:0]        pre_rem_q;
  logic [7:0]        first_q;
  logic              have_first_q;
  logic [3:0]        mem_rd_q;
  logic [3:0]        digit_mem [MaxDigits];

  // Clamp of a base write.
  logic [4:0] base_wr;
  always_comb begin
    if (cfg_data_i < BaseMin) begin
      base_wr = BaseMin;
    end else if (cfg_data_i > BaseMax) begin
      base_wr = BaseMax;
    end else begin
      base_wr = cfg_data_i;
    end
  end

  // Sign handling and prefix selection for a new value.
  logic        neg;
  logic [15:0] pre_init;
  logic [1:0]  pre_len;
  always_comb begin
    neg      = sgn_q && (base_q == BaseReset) && value_bits_i[63];
    pre_init = {ChrNone, ChrNone};
    pre_len  = 2'd0;
    if (neg) begin
      pre_init = {ChrMinus, ChrNone};
      pre_len  = 2'd1;
    end else if (pfx_en_q) begin
      if (base_q == BaseMax) begin
        pre_init = {ChrZero, ChrX};
        pre_len  = 2'd2;
      end else if (base_q == BaseEight) begin
        pre_init = {ChrZero, ChrNone};
        pre_len  = 2'd1;
      end else if (base_q == BaseMin) begin
        pre_init = {ChrUpB, ChrNone};
        pre_len  = 2'd1;
      end
    end
  end

  // Eight long-division steps per cycle, dividend bits taken from the top.
  logic [3:0]  rem_nxt;
  logic [7:0]  qbits;
  logic [63:0] work_nxt;
  always_comb begin
    logic [4:0] r;
    rem_nxt = rem_q;
    qbits   = '0;
    for (int i = 0; i < 8; i++) begin
      r = {rem_nxt, work_q[63-i]};
      if (r >= base_q) begin
        r            = r - base_q;
        qbits[7-i]   = 1'b1;
      end
      rem_nxt = r[3:0];
    end
    work_nxt = {work_q[55:0], qbits};
  end

  logic digit_end;
  assign digit_end       = cmd_i.div_step && (step_q == 3'd7);
  assign sts_o.div_last  = digit_end &&
                           ((work_nxt == 64'd0) || (count_q == CountW'(MaxDigits - 1)));

  // Character selection and beat packing.
  logic [7:0]        ch;
  logic              from_pre;
  logic [1:0]        pre_rem_nxt;
  logic [CountW-1:0] dig_rem_nxt;
  logic              is_last;
  always_comb begin
    from_pre    = (pre_rem_q != 2'd0);
    ch          = from_pre ? pre_q[15:8] : digit_char(mem_rd_q);
    pre_rem_nxt = from_pre ? pre_rem_q - 2'd1 : pre_rem_q;
    dig_rem_nxt = from_pre ? dig_rem_q : dig_rem_q - CountW'(1);
    is_last     = (pre_rem_nxt == 2'd0) && (dig_rem_nxt == '0);
  end
  assign sts_o.beat_done = have_first_q || is_last;
  assign sts_o.out_last  = last_o;

  logic [AddrW-1:0] rd_addr;
  assign rd_addr = AddrW'(dig_rem_q - CountW'(1));

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= BaseReset;
      pfx_en_q     <= 1'b0;
      sgn_q        <= 1'b0;
      step_q       <= '0;
      count_q      <= '0;
      dig_rem_q    <= '0;
      pre_rem_q    <= '0;
      have_first_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegBase:   base_q   <= base_wr;
          RegPrefix: pfx_en_q <= cfg_data_i[0];
          RegSigned: sgn_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        step_q       <= '0;
        count_q      <= '0;
        pre_rem_q    <= pre_len;
        have_first_q <= 1'b0;
      end
      if (cmd_i.div_step) begin
        step_q <= step_q + 3'd1;
        if (digit_end) begin
          count_q   <= count_q + CountW'(1);
          dig_rem_q <= count_q + CountW'(1);
        end
      end
      if (cmd_i.ch) begin
        pre_rem_q    <= pre_rem_nxt;
        dig_rem_q    <= dig_rem_nxt;
        have_first_q <= !sts_o.beat_done;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q <= neg ? 64'd0 - value_bits_i : value_bits_i;
      rem_q  <= '0;
      pre_q  <= pre_init;
    end
    if (cmd_i.div_step) begin
      work_q <= work_nxt;
      rem_q  <= digit_end ? 4'd0 : rem_nxt;
    end
    if (cmd_i.ch) begin
      if (from_pre) begin
        pre_q <= {pre_q[7:0], ChrNone};
      end
      if (sts_o.beat_done) begin
        char_first_o   <= have_first_q ? first_q : ch;
        char_second_o  <= have_first_q ? ch : ChrNone;
        second_valid_o <= have_first_q;
        last_o         <= is_last;
      end else begin
        first_q <= ch;
      end
    end
  end

  // Digit store: written once per digit, read once per character.
  always_ff @(posedge clk_i) begin
    if (digit_end) begin
      digit_mem[count_q[AddrW-1:0]] <= rem_nxt;
    end
    if (cmd_i.rd) begin
      mem_rd_q <= digit_mem[rd_addr];
    end
  end

endmodule

### hdl/int64_to_radix_text.sv
// Top level of the 64-bit integer to radix text converter.
// Converts one 64-bit value to ASCII text in base 2 to 16, most significant
// character first, two characters per output beat; a beat with second_valid_o
// low carries one character, and last_o marks the final beat of a value. One
// value is worked on at a time: in_stall_o stays high from acceptance until the
// last beat is taken. The divider produces eight quotient bits per cycle and
// finishes a digit once all 64 bits have passed through it; each character then
// costs a digit store read and a packing step.
// Configuration writes take effect at once and belong to idle periods.
module int64_to_radix_text (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  char_first_o,
  output logic [7:0]  char_second_o,
  output logic        second_valid_o,
  output logic        last_o
);
  import i2rt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of division, character fetch and beat delivery.
  i2rt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic, digit storage and output registers.
  i2rt_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .value_bits_i   (value_bits_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .char_first_o   (char_first_o),
    .char_second_o  (char_second_o),
    .second_valid_o (second_valid_o),
    .last_o         (last_o)
  );

endmodule

### hdl/i2rt_checker.sv
// Port-level checker of the radix text converter and its bind statement.
`include "int64_to_radix_text_defines.svh"

module i2rt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  char_first_o,
  input logic [7:0]  char_second_o,
  input logic        second_valid_o,
  input logic        last_o
);

  // A beat held back by the sink stays offered.
  `I2RT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "output beat dropped")

  // A held beat keeps its payload.
  `I2RT_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(char_first_o) && $stable(char_second_o) && $stable(second_valid_o) && $stable(last_o), "held beat changed")

  // The block only takes a value when no beat is pending.
  `I2RT_ASSERT(a_idle_no_out, !in_stall_o |-> !out_valid_o, "input open while beat pending")

  // One value at a time: the input closes right after acceptance.
  `I2RT_ASSERT(a_one_value, in_valid_i && !in_stall_o |=> in_stall_o, "second value taken early")

  // A single-character beat can only end the text.
  `I2RT_ASSERT(a_odd_tail, out_valid_o && !second_valid_o |-> last_o && (char_second_o == 8'h00), "short beat not final")

endmodule

bind int64_to_radix_text i2rt_checker u_i2rt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .char_first_o   (char_first_o),
  .char_second_o  (char_second_o),
  .second_valid_o (second_valid_o),
  .last_o         (last_o)
);

### bench/tb_int64_to_radix_text.sv
// Self-checking testbench for the 64-bit integer to radix text converter.
module tb_int64_to_radix_text;
  timeunit 1ns;
  timeprecision 1ps;

  import i2rt_pkg::*;

  localparam logic [1:0] RegSpare    = 2'd3;
  localparam logic [4:0] BaseDecimal = 5'd10;
  localparam int         NumDirected = 25;
  localparam int         PhaseItems  = 16;
  localparam int         NumPhases   = 6;
  localparam int         LongHold    = 400;

  typedef logic [7:0] text_t[$];

  // One output beat as the block should present it.
  typedef struct packed {
    logic [7:0] char_first;
    logic [7:0] char_second;
    logic       second_ok;
    logic       final_beat;
  } text_beat_t;

  // One directed value with the register setting it runs under.
  typedef struct {
    logic [4:0]  base_w;
    logic        prefix_w;
    logic        signed_w;
    bit          poke_spare;
    logic [63:0] value;
    string       text;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [4:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] value_bits;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  char_first;
  logic [7:0]  char_second;
  logic        second_valid;
  logic        last_beat;

  // Register mirror used by the text predictor.
  logic [4:0]  cfg_base   = BaseReset;
  logic        cfg_prefix = 1'b0;
  logic        cfg_signed = 1'b0;

  text_beat_t  expected_beats_q[$];
  string       typed_text_q[$];
  int          mismatches = 0;
  bit          hold_request = 1'b0;

  int64_to_radix_text u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .value_bits_i   (value_bits),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .char_first_o   (char_first),
    .char_second_o  (char_second),
    .second_valid_o (second_valid),
    .last_o         (last_beat)
  );

  always #6 clk = ~clk;

  // Text of one value under the current register setting.
  function automatic text_t radix_text_of(input logic [63:0] raw);
    text_t       txt;
    logic [63:0] mag;
    logic [63:0] radix;
    logic [3:0]  d;
    logic        neg;
    radix = {59'd0, cfg_base};
    neg   = cfg_signed && (cfg_base == BaseDecimal) && raw[63];
    mag   = neg ? (64'd0 - raw) : raw;
    // Digits come out least significant first, so build the text from the back.
    do begin
      d = 4'(mag % radix);
      txt.push_front((d < 4'd10) ? ChrZero + {4'd0, d} : ChrLowA + {4'd0, d} - 8'd10);
      mag = mag / radix;
    end while (mag != 64'd0);
    if (neg) begin
      txt.push_front(ChrMinus);
    end else if (cfg_prefix) begin
      if (cfg_base == BaseMax) begin
        txt.push_front(ChrX);
        txt.push_front(ChrZero);
      end else if (cfg_base == BaseEight) begin
        txt.push_front(ChrZero);
      end else if (cfg_base == BaseMin) begin
        txt.push_front(ChrUpB);
      end
    end
    return txt;
  endfunction

  // Mix of full-width, small, shifted and negative values.
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(0, 40));
      2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      3: v = 64'd0 - 64'($urandom_range(1, 1000));
      4: v = {1'b1, 63'd0} ^ 64'($urandom_range(0, 3));
      default: v = {64{1'b1}} >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  // Offer one value and hold it until the block takes it.
  task automatic offer_value(input logic [63:0] v, input string typed);
    typed_text_q.push_back(typed);
    in_valid   <= 1'b1;
    value_bits <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait until every expected beat has been taken.
  task automatic wait_drained();
    @(posedge clk);
    while (expected_beats_q.size() != 0) @(posedge clk);
  endtask

  // Write all three registers, optionally followed by a write to the unused index.
  task automatic program_regs(input logic [4:0] base_w, input logic [4:0] prefix_w,
                              input logic [4:0] signed_w, input bit poke_spare);
    cfg_we   <= 1'b1;
    cfg_idx  <= RegBase;
    cfg_data <= base_w;
    @(posedge clk);
    cfg_idx  <= RegPrefix;
    cfg_data <= prefix_w;
    @(posedge clk);
    cfg_idx  <= RegSigned;
    cfg_data <= signed_w;
    @(posedge clk);
    if (poke_spare) begin
      cfg_idx  <= RegSpare;
      cfg_data <= ~base_w;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    if (base_w < BaseMin) begin
      cfg_base = BaseMin;
    end else if (base_w > BaseMax) begin
      cfg_base = BaseMax;
    end else begin
      cfg_base = base_w;
    end
    cfg_prefix = prefix_w[0];
    cfg_signed = signed_w[0];
  endtask

  // Each accepted value queues the beats of its text.
  always @(posedge clk) begin : value_accept
    text_t      txt;
    string      typed;
    text_beat_t b;
    if (rst_n && in_valid && !in_stall) begin
      typed = typed_text_q.pop_front();
      if (typed.len() != 0) begin
        txt.delete();
        for (int i = 0; i < typed.len(); i++) txt.push_back(typed[i]);
      end else begin
        txt = radix_text_of(value_bits);
      end
      for (int k = 0; k < txt.size(); k += 2) begin
        b.char_first  = txt[k];
        b.second_ok   = (k + 1 < txt.size());
        b.char_second = b.second_ok ? txt[k + 1] : ChrNone;
        b.final_beat  = (k + 2 >= txt.size());
        expected_beats_q.push_back(b);
      end
    end
  end

  // Each accepted output beat is compared with the oldest expected one.
  always @(posedge clk) begin : beat_check
    text_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats_q.size() == 0) begin
        $error("Output beat arrived with no text pending.");
        mismatches++;
      end else begin
        want = expected_beats_q.pop_front();
        if (char_first !== want.char_first) begin
          $error("char_first: expected %h, got %h", want.char_first, char_first);
          mismatches++;
        end
        if (char_second !== want.char_second) begin
          $error("char_second: expected %h, got %h", want.char_second, char_second);
          mismatches++;
        end
        if (second_valid !== want.second_ok) begin
          $error("second_valid: expected %b, got %b", want.second_ok, second_valid);
          mismatches++;
        end
        if (last_beat !== want.final_beat) begin
          $error("last: expected %b, got %b", want.final_beat, last_beat);
          mismatches++;
        end
      end
    end
  end

  // Receiver: stretches of differing stall patterns, plus one long hold on request.
  initial begin : receiver
    int stretch;
    int mode;
    out_stall <= 1'b0;
    forever begin
      stretch = $urandom_range(20, 150);
      mode    = $urandom_range(0, 3);
      repeat (stretch) begin
        @(posedge clk);
        if (hold_request) begin
          hold_request = 1'b0;
          out_stall <= 1'b1;
          repeat (LongHold - 1) @(posedge clk);
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

  // Directed values first, then random phases under changing register settings.
  initial begin : stimulus
    dir_row_t   rows[NumDirected];
    logic [4:0] last_base;
    logic       last_prefix;
    logic       last_signed;
    logic [4:0] base_w;
    logic [4:0] prefix_w;
    logic [4:0] signed_w;
    int         sent;
    int         burst;
    bit         gaps_on;

    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= RegBase;
    cfg_data   <= 5'd0;
    in_valid   <= 1'b0;
    value_bits <= 64'd0;

    rows = '{
      '{5'd10, 1'b0, 1'b0, 1'b0, 64'd0, "0"},
      '{5'd10, 1'b0, 1'b0, 1'b0, {64{1'b1}}, "18446744073709551615"},
      '{5'd10, 1'b0, 1'b0, 1'b0, 64'd9, "9"},
      '{5'd10, 1'b0, 1'b0, 1'b0, 64'd10, "10"},
      '{5'd10, 1'b0, 1'b1, 1'b0, 64'h8000_0000_0000_0000, "-9223372036854775808"},
      '{5'd10, 1'b0, 1'b1, 1'b0, {64{1'b1}}, "-1"},
      '{5'd10, 1'b0, 1'b1, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, "9223372036854775807"},
      '{5'd10, 1'b1, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_CFC7, "-12345"},
      '{5'd16, 1'b1, 1'b0, 1'b0, {64{1'b1}}, "0xffffffffffffffff"},
      '{5'd16, 1'b1, 1'b1, 1'b0, 64'h8000_0000_0000_0000, "0x8000000000000000"},
      '{5'd16, 1'b0, 1'b1, 1'b0, 64'hDEAD_BEEF, "deadbeef"},
      '{5'd16, 1'b1, 1'b0, 1'b0, 64'd0, "0x0"},
      '{5'd8,  1'b1, 1'b0, 1'b0, 64'd0, "00"},
      '{5'd8,  1'b1, 1'b0, 1'b0, {64{1'b1}}, ""},
      '{5'd8,  1'b0, 1'b0, 1'b0, 64'd8, "10"},
      '{5'd2,  1'b1, 1'b0, 1'b0, {64{1'b1}}, ""},
      '{5'd2,  1'b1, 1'b0, 1'b0, 64'd0, "B0"},
      '{5'd2,  1'b1, 1'b1, 1'b0, 64'h8000_0000_0000_0000, ""},
      '{5'd2,  1'b0, 1'b0, 1'b0, 64'd5, "101"},
      '{5'd0,  1'b0, 1'b0, 1'b0, 64'd6, "110"},
      '{5'd1,  1'b1, 1'b0, 1'b0, 64'd3, "B11"},
      '{5'd31, 1'b0, 1'b0, 1'b0, 64'hAB, "ab"},
      '{5'd17, 1'b1, 1'b0, 1'b0, 64'd1, "0x1"},
      '{5'd16, 1'b1, 1'b0, 1'b1, 64'd16, "0x10"},
      '{5'd3,  1'b1, 1'b1, 1'b0, {64{1'b1}}, ""}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first rows run on the register values left by reset.
    last_base   = BaseReset;
    last_prefix = 1'b0;
    last_signed = 1'b0;
    foreach (rows[i]) begin
      if (rows[i].base_w != last_base || rows[i].prefix_w != last_prefix ||
          rows[i].signed_w != last_signed || rows[i].poke_spare) begin
        in_valid <= 1'b0;
        wait_drained();
        program_regs(rows[i].base_w, {4'd0, rows[i].prefix_w}, {4'd0, rows[i].signed_w},
                     rows[i].poke_spare);
        last_base   = rows[i].base_w;
        last_prefix = rows[i].prefix_w;
        last_signed = rows[i].signed_w;
      end
      // A typed text, where given, takes the place of the predictor.
      offer_value(rows[i].value, rows[i].text);
    end
    in_valid <= 1'b0;

    for (int phase = 0; phase < NumPhases; phase++) begin
      // The sender pauses here until the block has delivered everything.
      wait_drained();
      prefix_w = 5'($urandom_range(0, 31));
      signed_w = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 4) == 0) begin
        base_w = 5'($urandom_range(0, 31));
      end else begin
        base_w = 5'($urandom_range(2, 16));
      end
      case (phase)
        0: begin
          base_w      = BaseDecimal;
          signed_w[0] = 1'b1;
        end
        1: begin
          base_w      = BaseMin;
          prefix_w[0] = 1'b1;
        end
        5: base_w = BaseMax;
        default: ;
      endcase
      program_regs(base_w, prefix_w, signed_w, 1'b0);

      // Phases 2 and 5 run back to back; in phase 2 the receiver also holds off for a long time.
      gaps_on = (phase % 3 != 2);
      if (phase == 2) begin
        hold_request = 1'b1;
      end
      sent = 0;
      while (sent < PhaseItems) begin
        burst = $urandom_range(1, 6);
        for (int j = 0; j < burst && sent < PhaseItems; j++) begin
          offer_value(pick_value(), "");
          sent++;
        end
        if (gaps_on) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Generous bound on the whole run.
  initial begin : watchdog
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
